// ----- rtl/core/task_queue_and_timer_scheduler_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef TASK_QUEUE_AND_TIMER_SCHEDULER_TOP_DEFINES_SVH
`define TASK_QUEUE_AND_TIMER_SCHEDULER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TQS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("lbl failed");
// Implication checked on every clock edge, reset included.
`define TQS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("lbl failed");
`endif

// ----- rtl/core/tqs_pkg.sv -----
// Shared types and codes for the task queue and timer scheduler.
package tqs_pkg;
   typedef enum logic [2:0] {
      FUNC_ENQUEUE  = 3'd0,
      FUNC_STOP     = 3'd1,
      FUNC_ARM      = 3'd2,
      FUNC_DISPATCH = 3'd3,
      FUNC_TICK     = 3'd4
   } func_type;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_QUEUE_FULL = 2'd1;
   localparam logic [1:0] STATUS_TIMER_FULL = 2'd2;

   localparam logic [4:0] LOST_MAX = 5'd31;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_QSCAN   = 6'b000010,
      ST_QSHIFT  = 6'b000100,
      ST_TSCAN   = 6'b001000,
      ST_TSHIFT  = 6'b010000,
      ST_RESP    = 6'b100000
   } state_type;
endpackage

// ----- rtl/core/task_queue_and_timer_scheduler_top.sv -----
// Task queue with software timers: top level.
// The block is not ready while a request is being worked on. Enqueue and
// unused codes go straight to the response state; dispatch walks the queue
// one slot a cycle, shifting it forward; tick walks the timer table one slot a
// cycle through one shared compare/decrement unit; arm makes a match pass and,
// if no slot matches, a free-slot pass; stop scans the queue and shifts it
// when the task is found, then does the same on the timer table. The
// result is held in an output register; a new request is taken once the result
// has been handed off. Unused func codes answer all zero. No clearing pass
// after reset: all stores are flip-flops cleared at once.
module task_queue_and_timer_scheduler_top #(
   parameter int QUEUE_SLOTS  = 16,
   parameter int TIMER_SLOTS  = 16,
   parameter int TASK_ID_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_task_id,
   input  logic [31:0] req_delay_ticks,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_run_task,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_dropped_count
);
   localparam int QW = $clog2(QUEUE_SLOTS);
   localparam int TW = $clog2(TIMER_SLOTS);
   localparam int CW = $clog2(QUEUE_SLOTS + 1);

   tqs_pkg::state_type state_ff, state_in;
   logic [TASK_ID_BITS-1:0] queue_ff [QUEUE_SLOTS];
   logic [TASK_ID_BITS-1:0] ttask_ff [TIMER_SLOTS];
   logic [31:0]             tcount_ff [TIMER_SLOTS];
   logic [CW-1:0]           count_ff;
   logic [2:0]              func_ff;
   logic [TASK_ID_BITS-1:0] id_ff;
   logic [31:0]             delay_ff;
   logic [QW-1:0]           qidx_ff;
   logic [TW-1:0]           tidx_ff;
   logic                    pass_ff;   // arm: 0 match pass, 1 free pass
   logic [4:0]              lost_ff;
   logic                    rsp_valid_ff;
   logic [7:0]              run_ff;
   logic [1:0]              status_ff;

   logic [TASK_ID_BITS-1:0] id_w;
   logic [TASK_ID_BITS-1:0] cur_task;
   logic [31:0]             cur_cnt;
   logic                    q_last, t_last;
   logic                    q_full;

   assign id_w     = TASK_ID_BITS'(req_task_id);
   assign cur_task = ttask_ff[tidx_ff];
   assign cur_cnt  = tcount_ff[tidx_ff];
   assign q_last   = ({{(32-QW){1'b0}}, qidx_ff} + 32'd1) >= 32'(count_ff);
   assign t_last   = {{(32-TW){1'b0}}, tidx_ff} == 32'(TIMER_SLOTS - 1);
   assign q_full   = 32'(count_ff) >= 32'(QUEUE_SLOTS);

   assign req_ready         = state_ff == tqs_pkg::ST_IDLE && !rsp_valid_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_run_task      = run_ff;
   assign rsp_status        = status_ff;
   assign rsp_dropped_count = lost_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tqs_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_func)
                  tqs_pkg::FUNC_STOP:     state_in = tqs_pkg::ST_QSCAN;
                  tqs_pkg::FUNC_DISPATCH: state_in = tqs_pkg::ST_QSHIFT;
                  tqs_pkg::FUNC_ARM, tqs_pkg::FUNC_TICK:
                                          state_in = tqs_pkg::ST_TSCAN;
                  default:                state_in = tqs_pkg::ST_RESP;
               endcase
            end
         end
         tqs_pkg::ST_QSCAN: begin
            if (count_ff == '0 || (queue_ff[qidx_ff] == id_ff && id_ff != '0))
               state_in = tqs_pkg::ST_QSHIFT;
            else if (q_last)
               state_in = tqs_pkg::ST_TSCAN;
         end
         tqs_pkg::ST_QSHIFT: begin
            if (count_ff == '0 || q_last)
               state_in = (func_ff == tqs_pkg::FUNC_STOP) ? tqs_pkg::ST_TSCAN
                                                          : tqs_pkg::ST_RESP;
         end
         tqs_pkg::ST_TSCAN: begin
            if (func_ff == tqs_pkg::FUNC_STOP) begin
               if (cur_task == id_ff) state_in = tqs_pkg::ST_TSHIFT;
               else if (t_last)       state_in = tqs_pkg::ST_RESP;
            end else if (func_ff == tqs_pkg::FUNC_ARM) begin
               if ((!pass_ff && cur_task == id_ff) || (pass_ff && cur_task == '0))
                  state_in = tqs_pkg::ST_RESP;
               else if (t_last && pass_ff)
                  state_in = tqs_pkg::ST_RESP;
            end else if (t_last) begin
               state_in = tqs_pkg::ST_RESP;
            end
         end
         tqs_pkg::ST_TSHIFT: if (t_last) state_in = tqs_pkg::ST_RESP;
         tqs_pkg::ST_RESP: state_in = tqs_pkg::ST_IDLE;
         default: state_in = tqs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tqs_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < QUEUE_SLOTS; i++) queue_ff[i] <= '0;
         for (int i = 0; i < TIMER_SLOTS; i++) begin
            ttask_ff[i]  <= '0;
            tcount_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            tqs_pkg::ST_IDLE: begin
               if (req_valid && req_ready) begin
                  func_ff  <= req_func;
                  id_ff    <= id_w;
                  delay_ff <= req_delay_ticks;
                  qidx_ff  <= '0;
                  tidx_ff  <= '0;
                  pass_ff  <= 1'b0;
                  lost_ff  <= '0;
                  run_ff   <= (req_func == tqs_pkg::FUNC_DISPATCH && count_ff != '0)
                              ? 8'(queue_ff[0]) : 8'd0;
                  status_ff <= (req_func == tqs_pkg::FUNC_ENQUEUE && id_w != '0 && q_full)
                               ? tqs_pkg::STATUS_QUEUE_FULL : tqs_pkg::STATUS_OK;
                  if (req_func == tqs_pkg::FUNC_ENQUEUE && id_w != '0 && !q_full) begin
                     queue_ff[count_ff[QW-1:0]] <= id_w;
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            tqs_pkg::ST_QSCAN: begin
               if (!(count_ff == '0 || (queue_ff[qidx_ff] == id_ff && id_ff != '0))) begin
                  if (!q_last) qidx_ff <= qidx_ff + 1'b1;
               end
            end
            tqs_pkg::ST_QSHIFT: begin
               if (count_ff != '0) begin
                  if (q_last) begin
                     queue_ff[qidx_ff] <= '0;
                     count_ff <= count_ff - 1'b1;
                  end else begin
                     queue_ff[qidx_ff] <= queue_ff[qidx_ff + 1'b1];
                     qidx_ff <= qidx_ff + 1'b1;
                  end
               end
            end
            tqs_pkg::ST_TSCAN: begin
               if (func_ff == tqs_pkg::FUNC_STOP) begin
                  if (cur_task != id_ff && !t_last) tidx_ff <= tidx_ff + 1'b1;
               end else if (func_ff == tqs_pkg::FUNC_ARM) begin
                  if (!pass_ff && cur_task == id_ff) begin
                     tcount_ff[tidx_ff] <= delay_ff;
                  end else if (pass_ff && cur_task == '0) begin
                     ttask_ff[tidx_ff]  <= id_ff;
                     tcount_ff[tidx_ff] <= delay_ff;
                  end else if (t_last) begin
                     if (pass_ff) status_ff <= tqs_pkg::STATUS_TIMER_FULL;
                     pass_ff <= 1'b1;
                     tidx_ff <= '0;
                  end else tidx_ff <= tidx_ff + 1'b1;
               end else begin
                  // tick: one slot per cycle through the shared decrementer
                  if (cur_task != '0) begin
                     if (cur_cnt != '0) tcount_ff[tidx_ff] <= cur_cnt - 32'd1;
                     else begin
                        ttask_ff[tidx_ff] <= '0;
                        if (q_full) begin
                           if (lost_ff != tqs_pkg::LOST_MAX) lost_ff <= lost_ff + 1'b1;
                           status_ff <= tqs_pkg::STATUS_QUEUE_FULL;
                        end else begin
                           queue_ff[count_ff[QW-1:0]] <= cur_task;
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                  end
                  if (!t_last) tidx_ff <= tidx_ff + 1'b1;
               end
            end
            tqs_pkg::ST_TSHIFT: begin
               if (t_last) begin
                  ttask_ff[tidx_ff]  <= '0;
                  tcount_ff[tidx_ff] <= '0;
               end else begin
                  ttask_ff[tidx_ff]  <= ttask_ff[tidx_ff + 1'b1];
                  tcount_ff[tidx_ff] <= tcount_ff[tidx_ff + 1'b1];
                  tidx_ff <= tidx_ff + 1'b1;
               end
            end
            tqs_pkg::ST_RESP: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end
endmodule

// ----- rtl/core/tqs_checker.sv -----
// Port-level checker for the scheduler, bound to the top level.
`include "task_queue_and_timer_scheduler_top_defines.svh"
module tqs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_run_task,
   input logic [1:0] rsp_status,
   input logic [4:0] rsp_dropped_count
);
   `TQS_ASSERT(rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_run_task))
   `TQS_ASSERT(no_accept_while_rsp, clock, reset, rsp_valid |-> !req_ready)
   `TQS_ASSERT(accept_then_busy, clock, reset, req_valid && req_ready |=> !req_ready)
   `TQS_ASSERT(lost_implies_status, clock, reset,
      rsp_valid && rsp_dropped_count != '0 |-> rsp_status == tqs_pkg::STATUS_QUEUE_FULL)
   `TQS_ASSERT_ALWAYS(rst_clear, clock, reset |=> !rsp_valid)
endmodule

bind task_queue_and_timer_scheduler_top tqs_checker u_tqs_checker (.*);
